/* hw/rtl/ptb_pkg.sv */
// Shared types and constants for the palette tint blend pipeline.
`default_nettype none

package ptb_pkg;

   localparam int NumStages    = 6;
   localparam int ScaleShift   = 9;
   localparam int ProdWidth    = 17;
   localparam int Div255Shift  = 8;
   localparam int DeltaWidth   = 16;
   localparam int MagWidth     = 15;
   localparam int Recip100Bits = 13;
   localparam int Recip100Shift = 19;
   localparam int QuotWidth    = 28;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 9;

   localparam logic [Recip100Bits-1:0] Recip100 = 13'd5243;

   typedef enum logic [CsrIndexWidth-1:0] {
      CsrTargetRed   = 3'd0,
      CsrTargetGreen = 3'd1,
      CsrTargetBlue  = 3'd2,
      CsrBlendPct    = 3'd3,
      CsrSkipA       = 3'd4,
      CsrSkipB       = 3'd5
   } ptb_csr_type;

   typedef struct packed {
      logic [7:0] entry_index;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [7:0] flags_in;
   } ptb_req_type;

   typedef struct packed {
      logic [7:0] index_out;
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [7:0] flags_out;
   } ptb_rsp_type;

   typedef struct packed {
      logic [NumStages-1:0] load;
      logic [NumStages-1:0] valid;
   } ptb_ctrl_type;

   typedef struct packed {
      logic [7:0] index;
      logic [7:0] flags;
      logic       skip;
   } ptb_meta_type;

endpackage

`default_nettype wire

/* hw/rtl/ptb_valid.sv */
// Valid bits and per-stage load enables for the tint pipeline.
`default_nettype none

module ptb_valid (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 rsp_stall,
   output ptb_pkg::ptb_ctrl_type     ctrl,
   output logic                      req_stall,
   output logic                      rsp_valid
);
   import ptb_pkg::*;

   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] valid_in;
   logic [NumStages-1:0] ready;

   always_comb begin
      ready[NumStages-1] = !valid_ff[NumStages-1] || !rsp_stall;
      for (int k = NumStages - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      for (int k = 0; k < NumStages; k++) begin
         if (ready[k]) begin
            valid_in[k] = (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k - 1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.load  = ready;
   assign ctrl.valid = valid_ff;
   assign req_stall  = !ready[0];
   assign rsp_valid  = valid_ff[NumStages-1];

endmodule

`default_nettype wire

/* hw/rtl/ptb_front.sv */
// Channel sort and intensity stages of the tint pipeline.
`default_nettype none

module ptb_front (
   input  wire logic                 clock,
   input  wire ptb_pkg::ptb_ctrl_type ctrl,
   input  wire logic [7:0]           red_in,
   input  wire logic [7:0]           green_in,
   input  wire logic [7:0]           blue_in,
   output logic [7:0]                intensity
);
   import ptb_pkg::*;

   logic [7:0]           hi_a, md_a, hi_b, md_b, lo_b, hi_c, md_c;
   logic [7:0]           hi_ff;
   logic [8:0]           sum_ff;
   logic [7:0]           hi2_ff;
   logic [ProdWidth-1:0] prod_ff;
   logic [ProdWidth-1:0] prod_in;

   always_comb begin
      hi_a = (red_in < green_in) ? green_in : red_in;
      md_a = (red_in < green_in) ? red_in : green_in;
      md_b = (md_a < blue_in) ? blue_in : md_a;
      lo_b = (md_a < blue_in) ? md_a : blue_in;
      hi_b = hi_a;
      hi_c = (hi_b < md_b) ? md_b : hi_b;
      md_c = (hi_b < md_b) ? hi_b : md_b;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         hi_ff  <= hi_c;
         sum_ff <= 9'(md_c) + 9'(lo_b);
      end
   end

   assign prod_in = ProdWidth'(sum_ff) * ProdWidth'(8'hff - hi_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         hi2_ff  <= hi_ff;
         prod_ff <= prod_in;
      end
   end

   assign intensity = hi2_ff + 8'(prod_ff >> ScaleShift);

endmodule

`default_nettype wire

/* hw/rtl/ptb_chan.sv */
// Per-channel scale, blend, truncating divide and final add stages.
`default_nettype none

module ptb_chan (
   input  wire logic                 clock,
   input  wire ptb_pkg::ptb_ctrl_type ctrl,
   input  wire logic [7:0]           chan_in,
   input  wire logic [7:0]           target,
   input  wire logic [6:0]           percent,
   input  wire logic [7:0]           intensity,
   input  wire logic                 skip,
   output logic [7:0]                chan_out
);
   import ptb_pkg::*;

   logic [7:0]                  byte_ff [5];
   logic [15:0]                 x_ff;
   logic [16:0]                 x_adj;
   logic [7:0]                  scaled;
   logic signed [8:0]           diff;
   logic signed [7:0]           pct_s;
   logic signed [16:0]          prod_s;
   logic signed [DeltaWidth-1:0] delta_ff;
   logic [DeltaWidth-1:0]       mag_full;
   logic [MagWidth-1:0]         mag;
   logic [QuotWidth-1:0]        q_ff;
   logic                        neg_ff;
   logic [8:0]                  quo;
   logic [7:0]                  out_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         byte_ff[0] <= chan_in;
      end
      for (int k = 1; k < 5; k++) begin
         if (ctrl.load[k]) begin
            byte_ff[k] <= byte_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         x_ff <= 16'(target) * 16'(intensity);
      end
   end

   always_comb begin
      x_adj  = 17'(x_ff) + 17'(x_ff >> Div255Shift) + 17'd1;
      scaled = x_adj[15:8];
      diff   = $signed({1'b0, scaled}) - $signed({1'b0, byte_ff[2]});
      pct_s  = $signed({1'b0, percent});
      prod_s = diff * pct_s;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         delta_ff <= prod_s[DeltaWidth-1:0];
      end
   end

   always_comb begin
      mag_full = delta_ff[DeltaWidth-1] ? DeltaWidth'(-delta_ff) : DeltaWidth'(delta_ff);
      mag      = mag_full[MagWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         q_ff   <= QuotWidth'(mag) * QuotWidth'(Recip100);
         neg_ff <= delta_ff[DeltaWidth-1];
      end
   end

   assign quo = q_ff[Recip100Shift +: 9];

   always_ff @(posedge clock) begin
      if (ctrl.load[5]) begin
         if (skip) begin
            out_ff <= byte_ff[4];
         end else if (neg_ff) begin
            out_ff <= byte_ff[4] - quo[7:0];
         end else begin
            out_ff <= byte_ff[4] + quo[7:0];
         end
      end
   end

   assign chan_out = out_ff;

endmodule

`default_nettype wire

/* hw/rtl/palette_tint_blend_top.sv */
// Palette tint blend: top level with configuration registers and pipeline.
//
// Input channel req_*: one palette entry per transaction (index, red, green,
// blue, flags). Result channel rsp_*: one tinted entry per transaction, in
// order. Both use valid/stall; a transaction moves when valid is high and
// stall is low.
// Throughput is one entry per clock while rsp_stall is low, through the
// six-stage pipeline (sort, intensity multiply, target multiply, blend
// multiply, reciprocal divide, final add).
// Each stage holds its entry while the stage after it is full and blocked, so
// bubbles collapse and input is taken while a result waits on rsp_stall;
// req_stall rises only when all six stages hold entries and rsp_stall is high.
// csr_* writes a register by index: target red/green/blue, blend percent and
// two skip indexes (negative disables). Write only while the pipeline is empty.
// Synchronous reset empties the pipeline and restores targets and percent to
// zero and both skip indexes to -1.
`default_nettype none

module palette_tint_blend_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire ptb_pkg::ptb_req_type        req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output ptb_pkg::ptb_rsp_type             rsp_data,
   input  wire logic                        csr_wr_en,
   input  wire logic [ptb_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [ptb_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import ptb_pkg::*;

   logic [7:0]   target_red_ff, target_green_ff, target_blue_ff;
   logic [6:0]   blend_pct_ff;
   logic [8:0]   skip_a_ff, skip_b_ff;
   ptb_ctrl_type ctrl;
   ptb_meta_type meta_ff [NumStages];
   ptb_meta_type meta_in;
   logic [7:0]   intensity;
   logic [7:0]   red_res, green_res, blue_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_red_ff   <= '0;
         target_green_ff <= '0;
         target_blue_ff  <= '0;
         blend_pct_ff    <= '0;
         skip_a_ff       <= '1;
         skip_b_ff       <= '1;
      end else if (csr_wr_en) begin
         unique case (ptb_csr_type'(csr_index))
            CsrTargetRed:   target_red_ff   <= csr_wdata[7:0];
            CsrTargetGreen: target_green_ff <= csr_wdata[7:0];
            CsrTargetBlue:  target_blue_ff  <= csr_wdata[7:0];
            CsrBlendPct:    blend_pct_ff    <= csr_wdata[6:0];
            CsrSkipA:       skip_a_ff       <= csr_wdata;
            CsrSkipB:       skip_b_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      meta_in.index = req_data.entry_index;
      meta_in.flags = req_data.flags_in;
      meta_in.skip  = (!skip_a_ff[8] && skip_a_ff[7:0] == req_data.entry_index) ||
                      (!skip_b_ff[8] && skip_b_ff[7:0] == req_data.entry_index);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         meta_ff[0] <= meta_in;
      end
      for (int k = 1; k < NumStages; k++) begin
         if (ctrl.load[k]) begin
            meta_ff[k] <= meta_ff[k-1];
         end
      end
   end

   ptb_valid u_valid (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   ptb_front u_front (
      .clock     (clock),
      .ctrl      (ctrl),
      .red_in    (req_data.red_in),
      .green_in  (req_data.green_in),
      .blue_in   (req_data.blue_in),
      .intensity (intensity)
   );

   ptb_chan u_red (
      .clock     (clock),
      .ctrl      (ctrl),
      .chan_in   (req_data.red_in),
      .target    (target_red_ff),
      .percent   (blend_pct_ff),
      .intensity (intensity),
      .skip      (meta_ff[4].skip),
      .chan_out  (red_res)
   );

   ptb_chan u_green (
      .clock     (clock),
      .ctrl      (ctrl),
      .chan_in   (req_data.green_in),
      .target    (target_green_ff),
      .percent   (blend_pct_ff),
      .intensity (intensity),
      .skip      (meta_ff[4].skip),
      .chan_out  (green_res)
   );

   ptb_chan u_blue (
      .clock     (clock),
      .ctrl      (ctrl),
      .chan_in   (req_data.blue_in),
      .target    (target_blue_ff),
      .percent   (blend_pct_ff),
      .intensity (intensity),
      .skip      (meta_ff[4].skip),
      .chan_out  (blue_res)
   );

   always_comb begin
      rsp_data.index_out = meta_ff[NumStages-1].index;
      rsp_data.flags_out = meta_ff[NumStages-1].flags;
      rsp_data.red_out   = red_res;
      rsp_data.green_out = green_res;
      rsp_data.blue_out  = blue_res;
   end

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (ctrl.valid == '1 && rsp_stall))
      else $error("input stalled with a free pipeline stage");

   a_count_kept: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         ($countones(ctrl.valid) + $past(rsp_valid && !rsp_stall) ==
          $countones($past(ctrl.valid)) + $past(req_valid && !req_stall)))
      else $error("pipeline occupancy does not match transactions");

   a_tail_moves: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && ctrl.valid[NumStages-2]) |=> rsp_valid)
      else $error("queued entry did not advance to the output");

endmodule

`default_nettype wire
